>>> rtl/pcal_pkg.sv
// ----------------------------------------------------------------------------
// pcal_pkg: shared types and constants for the piecewise linear calibration
// Field widths, operation/channel/status codes, sequencer states and the
// Q16.16 saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcal_pkg;

  // Fixed field widths
  localparam int RAW_W   = 24;
  localparam int TGT_W   = 32;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int SEG_W   = 4;
  localparam int STAT_W  = 2;

  // Arithmetic widths: dx = x - r1, dt = t2 - t1, product of magnitudes
  localparam int DX_W    = RAW_W + 1;
  localparam int DT_W    = TGT_W + 1;
  localparam int DT_LO_W = 17;
  localparam int DT_HI_W = DT_W - DT_LO_W;
  localparam int PLO_W   = DX_W + DT_LO_W;
  localparam int PHI_W   = DX_W + DT_HI_W;
  localparam int PROD_W  = DX_W + DT_W;
  localparam int QS_W    = PROD_W + 1;

  // Operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // Channel codes
  localparam logic CH_WEIGHT   = 1'b0;
  localparam logic CH_DISTANCE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_WEIGHT_POINTS   = 1'b0;
  localparam logic CFG_DISTANCE_POINTS = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BELOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABOVE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DEGEN  = 2'd3;

  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_DECIDE,
    S_SCAN,
    S_LOAD_LO,
    S_LOAD_HI,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_START,
    S_DIV_WAIT,
    S_SUM,
    S_DONE
  } pcal_state_t;

  // One input beat
  typedef struct packed {
    logic                    op;
    logic                    channel;
    logic [IDX_W-1:0]        point_index;
    logic signed [RAW_W-1:0] raw;
    logic signed [TGT_W-1:0] target;
  } pcal_item_t;

  // One result beat
  typedef struct packed {
    logic signed [TGT_W-1:0] value;
    logic                    channel;
    logic [SEG_W-1:0]        segment;
    logic [STAT_W-1:0]       status;
    logic                    saturated;
  } pcal_result_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] value;
    logic                    sat;
  } pcal_sat_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic pcal_sat_t clamp_q(input logic signed [63:0] v);
    pcal_sat_t r;
    r.sat = 1'b1;
    if (v > Q_MAX) begin
      r.value = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r.value = 32'sh8000_0000;
    end else begin
      r.value = v[TGT_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/piecewise_linear_calibration_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_top: two-channel piecewise linear calibration
// A point write beat gives no result. A convert beat gives one result: an
// empty table goes straight to the output, a single point gives its target, a
// flat segment ends after the scan with no multiply or divide, and otherwise
// the segment scan, split multiply and two-bit-per-cycle divider run in turn.
// The next beat is taken once the result has left the sequencer.
// Reset clears the point counts and the output valid flag; tables hold no
// defined data until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_calibration_top #(
  parameter int POINTS        = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_index[3:0], raw[27:4], target[59:28], zero pad
  input  logic [1:0]  s_tuser,   // operation[0], channel[1]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value[31:0], segment[35:32], status[37:36],
                                 // saturated[38], zero pad
  output logic        m_tuser,   // channel_out
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  import pcal_pkg::*;

  localparam int DEPTH = 2 * POINTS;
  localparam int AW    = $clog2(DEPTH);

  pcal_item_t       item;
  pcal_result_t     res, out_res;
  logic             res_valid, res_ready;
  logic [CNT_W-1:0] weight_cnt, dist_cnt;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [RAW_W-1:0] rd_raw;
  logic [TGT_W-1:0] rd_tgt;

  // Unpack the input beat
  assign item.op          = s_tuser[0];
  assign item.channel     = s_tuser[1];
  assign item.point_index = s_tdata[3:0];
  assign item.raw         = s_tdata[27:4];
  assign item.target      = s_tdata[59:28];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_cnt <= '0;
      dist_cnt   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WEIGHT_POINTS:   weight_cnt <= cfg_data;
        CFG_DISTANCE_POINTS: dist_cnt   <= cfg_data;
      endcase
    end
  end

  // Calibration tables
  pcal_ram #(
    .WIDTH (RAW_W),
    .DEPTH (DEPTH)
  ) u_raw_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item.raw),
    .raddr (mem_raddr),
    .rdata (rd_raw)
  );

  pcal_ram #(
    .WIDTH (TGT_W),
    .DEPTH (DEPTH)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item.target),
    .raddr (mem_raddr),
    .rdata (rd_tgt)
  );

  pcal_seq #(
    .POINTS        (POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item       (item),
    .weight_cnt (weight_cnt),
    .dist_cnt   (dist_cnt),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_raddr  (mem_raddr),
    .rd_raw     (rd_raw),
    .rd_tgt     (rd_tgt),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.saturated, out_res.status, out_res.segment, out_res.value};
  assign m_tuser = out_res.channel;

  // A point write never holds up the input side
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == OP_WRITE |=> s_tready)
    else $error("point write did not return to idle");

  // A saturated value sits at one end of the range
  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.saturated |->
      out_res.value == 32'sh7FFF_FFFF || out_res.value == 32'sh8000_0000)
    else $error("saturated value is not a range limit");

  // Only the distance pass-through saturates on a degenerate table
  a_degen_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.saturated && out_res.status == STAT_DEGEN |->
      out_res.channel == CH_DISTANCE)
    else $error("degenerate weight result flagged as saturated");

endmodule

>>> rtl/pcal_ram.sv
// ----------------------------------------------------------------------------
// pcal_ram: generic single-write, single-read RAM
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pcal_div.sv
// ----------------------------------------------------------------------------
// pcal_div: unsigned restoring divider, two quotient bits per cycle
// Done pulses for one cycle when the quotient is complete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcal_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEPS = (NUM_W + 1) / 2;
  localparam int QW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [QW-1:0] acc, acc_next;
  logic [DEN_W-1:0] rem, rem_next;
  logic [DEN_W-1:0] den_r;

  // Two dependent compare-subtract steps
  always_comb begin
    logic [DEN_W:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, acc_next[QW-1]};
      acc_next = {acc_next[QW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_next    = DEN_W'(trial - {1'b0, den_r});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = DEN_W'(trial);
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= QW'(num);
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quot = acc[NUM_W-1:0];

endmodule

>>> rtl/pcal_seq.sv
// ----------------------------------------------------------------------------
// pcal_seq: table sequencer and interpolation datapath
// Writes points into the tables, walks a table for the segment, then runs a
// split multiply, the shared divider and the final add with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcal_seq #(
  parameter int POINTS        = 16,
  parameter int FRACTION_BITS = 16,
  localparam int AW           = $clog2(2 * POINTS)
) (
  input  logic                           clk,
  input  logic                           rst,
  // item in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pcal_pkg::pcal_item_t           item,
  // configuration
  input  logic [pcal_pkg::CNT_W-1:0]     weight_cnt,
  input  logic [pcal_pkg::CNT_W-1:0]     dist_cnt,
  // table memories
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [pcal_pkg::RAW_W-1:0]     rd_raw,
  input  logic [pcal_pkg::TGT_W-1:0]     rd_tgt,
  // result out
  output logic                           res_valid,
  input  logic                           res_ready,
  output pcal_pkg::pcal_result_t         res
);

  import pcal_pkg::*;

  localparam int IW  = $clog2(POINTS);
  localparam int CW0 = $clog2(POINTS + 1);
  localparam int CW  = (CW0 > CNT_W) ? CW0 : CNT_W;

  function automatic logic [AW-1:0] addr_of(input logic ch, input logic [IW-1:0] idx);
    return ch ? (AW'(POINTS) + AW'(idx)) : AW'(idx);
  endfunction

  pcal_state_t state, state_next;

  // Item registers
  logic                    ch;
  logic signed [RAW_W-1:0] x;
  logic [CW-1:0]           n_cnt;
  logic signed [RAW_W-1:0] first_raw;
  logic [IW-1:0]           scan_j;
  logic [IW-1:0]           seg_idx;
  logic signed [RAW_W-1:0] r1;
  logic signed [TGT_W-1:0] t1;

  // Arithmetic registers
  logic [DX_W-1:0]         dx_mag;
  logic [DT_W-1:0]         dt_mag;
  logic [DX_W-1:0]         den_mag;
  logic                    q_neg;
  logic [PLO_W-1:0]        prod_lo;
  logic [PHI_W-1:0]        prod_hi;
  logic signed [QS_W-1:0]  qs;

  // Combinational views
  logic                    in_accept;
  logic [CW-1:0]           n_in;
  logic signed [RAW_W-1:0] rd_raw_s;
  logic signed [TGT_W-1:0] rd_tgt_s;
  logic [IW-1:0]           seg_pick;
  logic [IW-1:0]           n_m1, n_m2;
  logic [STAT_W-1:0]       status_dec;
  logic signed [DX_W-1:0]  dx_w, dr_w;
  logic signed [DT_W-1:0]  dt_w;
  logic signed [63:0]      pass_w, sum_w;
  pcal_sat_t               pass_q, sum_q;
  logic [PROD_W-1:0]       div_num;
  logic                    div_start, div_done;
  logic [PROD_W-1:0]       div_quot;

  assign rd_raw_s = rd_raw;
  assign rd_tgt_s = rd_tgt;
  assign n_m1     = IW'(n_cnt - CW'(1));
  assign n_m2     = IW'(n_cnt - CW'(2));

  // Points in use, limited to the table size
  always_comb begin
    logic [CNT_W-1:0] c;
    c    = (item.channel == CH_DISTANCE) ? dist_cnt : weight_cnt;
    n_in = (CW'(c) > CW'(POINTS)) ? CW'(POINTS) : CW'(c);
  end

  // Pass-through for an empty distance table
  assign pass_w = {{(64 - RAW_W){item.raw[RAW_W-1]}}, item.raw} <<< FRACTION_BITS;
  assign pass_q = clamp_q(pass_w);

  // Differences against the lower point of the segment
  assign dx_w = {x[RAW_W-1], x} - {r1[RAW_W-1], r1};
  assign dr_w = {rd_raw_s[RAW_W-1], rd_raw_s} - {r1[RAW_W-1], r1};
  assign dt_w = {rd_tgt_s[TGT_W-1], rd_tgt_s} - {t1[TGT_W-1], t1};

  // Final sum and clamp
  assign sum_w = {{(64 - TGT_W){t1[TGT_W-1]}}, t1} + {{(64 - QS_W){qs[QS_W-1]}}, qs};
  assign sum_q = clamp_q(sum_w);

  // Numerator magnitude from the two partial products
  assign div_num = PROD_W'(prod_lo) + (PROD_W'(prod_hi) << DT_LO_W);

  // Position of the sample against the end points
  always_comb begin
    if (x < first_raw) begin
      status_dec = STAT_BELOW;
    end else if (x > rd_raw_s) begin
      status_dec = STAT_ABOVE;
    end else begin
      status_dec = STAT_INSIDE;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    in_accept  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_of(item.channel, IW'(item.point_index));
    mem_raddr  = addr_of(ch, '0);
    seg_pick   = seg_idx;
    div_start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        in_accept = in_valid;
        mem_raddr = addr_of(item.channel, '0);
        if (in_accept) begin
          if (item.op == OP_WRITE) begin
            mem_we = (32'(item.point_index) < 32'(POINTS));
          end else if (n_in == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        mem_raddr = addr_of(ch, n_m1);
        if (n_cnt == CW'(1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (x <= first_raw) begin
          seg_pick   = '0;
          state_next = S_LOAD_LO;
        end else if (x >= rd_raw_s) begin
          seg_pick   = n_m2;
          state_next = S_LOAD_LO;
        end else if (n_cnt == CW'(2)) begin
          seg_pick   = '0;
          state_next = S_LOAD_LO;
        end else begin
          state_next = S_SCAN;
        end
        mem_raddr = (state_next == S_SCAN) ? addr_of(ch, IW'(1)) : addr_of(ch, seg_pick);
      end
      S_SCAN: begin
        // read data holds the raw of entry scan_j
        if (x <= rd_raw_s) begin
          seg_pick   = scan_j - IW'(1);
          state_next = S_LOAD_LO;
          mem_raddr  = addr_of(ch, seg_pick);
        end else if (scan_j == n_m2) begin
          seg_pick   = n_m2;
          state_next = S_LOAD_LO;
          mem_raddr  = addr_of(ch, seg_pick);
        end else begin
          mem_raddr = addr_of(ch, scan_j + IW'(1));
        end
      end
      S_LOAD_LO: begin
        mem_raddr  = addr_of(ch, seg_idx + IW'(1));
        state_next = S_LOAD_HI;
      end
      S_LOAD_HI: begin
        state_next = (rd_raw_s == r1) ? S_DONE : S_MUL_LO;
      end
      S_MUL_LO: begin
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept && item.op == OP_CONVERT) begin
          ch            <= item.channel;
          x             <= item.raw;
          n_cnt         <= n_in;
          res.channel   <= item.channel;
          res.segment   <= '0;
          res.status    <= STAT_DEGEN;
          res.value     <= (item.channel == CH_DISTANCE) ? pass_q.value : '0;
          res.saturated <= (item.channel == CH_DISTANCE) ? pass_q.sat : 1'b0;
        end
      end
      S_FIRST: begin
        first_raw     <= rd_raw_s;
        res.value     <= rd_tgt_s;
        res.saturated <= 1'b0;
      end
      S_DECIDE: begin
        res.status <= status_dec;
        seg_idx    <= seg_pick;
        scan_j     <= IW'(1);
      end
      S_SCAN: begin
        seg_idx <= seg_pick;
        scan_j  <= scan_j + IW'(1);
      end
      S_LOAD_LO: begin
        r1 <= rd_raw_s;
        t1 <= rd_tgt_s;
      end
      S_LOAD_HI: begin
        res.segment <= SEG_W'(seg_idx);
        dx_mag      <= dx_w[DX_W-1] ? DX_W'(-dx_w) : DX_W'(dx_w);
        dt_mag      <= dt_w[DT_W-1] ? DT_W'(-dt_w) : DT_W'(dt_w);
        den_mag     <= dr_w[DX_W-1] ? DX_W'(-dr_w) : DX_W'(dr_w);
        q_neg       <= dx_w[DX_W-1] ^ dt_w[DT_W-1] ^ dr_w[DX_W-1];
        // equal raws give the lower target
        if (rd_raw_s == r1) begin
          res.value     <= t1;
          res.status    <= STAT_DEGEN;
          res.saturated <= 1'b0;
        end
      end
      S_MUL_LO: begin
        prod_lo <= PLO_W'(dx_mag) * PLO_W'(dt_mag[DT_LO_W-1:0]);
      end
      S_MUL_HI: begin
        prod_hi <= PHI_W'(dx_mag) * PHI_W'(dt_mag[DT_W-1:DT_LO_W]);
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          qs <= q_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        end
      end
      S_SUM: begin
        res.value     <= sum_q.value;
        res.saturated <= sum_q.sat;
      end
      default: begin
      end
    endcase
  end

  // Truncating divide of the magnitudes
  pcal_div #(
    .NUM_W (PROD_W),
    .DEN_W (DX_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den_mag),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the piecewise linear calibration block
// Point writes and sample conversions stream in on the slave side. Every
// accepted beat also runs through a behavioral copy of both calibration
// tables, which queues the expected result of each convert. Result beats are
// compared in order. Point counts change only while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pcal_pkg::*;

  localparam int N_POINTS      = 16;
  localparam int FRAC          = 16;
  localparam int SETTLE_CYCLES = 80;      // covers the worst convert
  localparam int CYCLE_LIMIT   = 600000;
  localparam int CALM_START    = 30000;   // window with no random idling
  localparam int CALM_END      = 36000;
  localparam int HOLD_CYCLES   = 600;     // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // point_index[3:0], raw[27:4], target[59:28], zero pad
  logic [1:0]  s_tuser = '0;   // operation[0], channel[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // value[31:0], segment[35:32], status[37:36],
                               // saturated[38], zero pad
  logic        m_tuser;        // channel_out
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;

  piecewise_linear_calibration_top #(
    .POINTS        (N_POINTS),
    .FRACTION_BITS (FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent, and calibrated values waiting to come back
  pcal_item_t   pending_items[$];
  pcal_result_t expected_results[$];

  // Shadow calibration tables, updated as write beats are accepted
  logic signed [RAW_W-1:0] cal_raw    [2][N_POINTS];
  logic signed [TGT_W-1:0] cal_target [2][N_POINTS];
  logic [CNT_W-1:0]        pts_used   [2] = '{5'd0, 5'd0};

  // Raw values as queued, used to aim samples at the table
  int plan_raw [2][N_POINTS];

  int cycle_count  = 0;
  int results_seen = 0;
  int fail_count   = 0;
  bit beat_taken   = 1'b0;

  wire calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Input side: on each accepted beat update the shadow tables or predict
  always @(posedge clk) begin : accept_blk
    pcal_item_t   it;
    pcal_result_t res;
    int           n, i, ch;
    longint       x, lo_raw, hi_raw, r1, r2, t1, t2, v;
    beat_taken = !rst && s_tvalid && s_tready;
    if (beat_taken) begin
      it = pending_items.pop_front();
      ch = it.channel;
      x  = longint'($signed(it.raw));
      if (it.op == OP_WRITE) begin
        cal_raw[ch][it.point_index]    = it.raw;
        cal_target[ch][it.point_index] = it.target;
      end else begin
        n = pts_used[ch];
        if (n > N_POINTS) n = N_POINTS;
        res.channel   = it.channel;
        res.segment   = '0;
        res.status    = STAT_DEGEN;
        res.saturated = 1'b0;
        v = 0;
        if (n == 0) begin
          // empty distance table passes the raw reading through
          if (it.channel == CH_DISTANCE) v = x * (longint'(1) << FRAC);
        end else if (n == 1) begin
          v = cal_target[ch][0];
        end else begin
          lo_raw = cal_raw[ch][0];
          hi_raw = cal_raw[ch][n-1];
          if (x <= lo_raw) begin
            i = 0;
          end else if (x >= hi_raw) begin
            i = n - 2;
          end else begin
            i = 0;
            while (i + 1 < n - 1 && x > cal_raw[ch][i+1]) i++;
          end
          if (x < lo_raw)      res.status = STAT_BELOW;
          else if (x > hi_raw) res.status = STAT_ABOVE;
          else                 res.status = STAT_INSIDE;
          r1 = cal_raw[ch][i];
          r2 = cal_raw[ch][i+1];
          t1 = cal_target[ch][i];
          t2 = cal_target[ch][i+1];
          res.segment = i[SEG_W-1:0];
          if (r1 == r2) begin
            // flat segment: lower target, no divide
            v = t1;
            res.status = STAT_DEGEN;
          end else begin
            v = t1 + ((x - r1) * (t2 - t1)) / (r2 - r1);
          end
        end
        // saturate to Q16.16
        if (v > Q_MAX) begin
          v = Q_MAX;
          res.saturated = 1'b1;
        end else if (v < Q_MIN) begin
          v = Q_MIN;
          res.saturated = 1'b1;
        end
        res.value = v[TGT_W-1:0];
        expected_results.push_back(res);
      end
    end
  end

  // Driver: a beat is held until taken; outside the calm window new beats may wait a random gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !beat_taken) begin
      // hold the offered beat
    end else if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
      s_tvalid <= 1'b1;
      s_tdata  <= {4'b0, pending_items[0].target, pending_items[0].raw,
                   pending_items[0].point_index};
      s_tuser  <= {pending_items[0].channel, pending_items[0].op};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure plus one long hold-off mid stream
  int hold_left = 0;
  bit held_once = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held_once && results_seen >= 150 && pending_items.size() > 20) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin : check_blk
    pcal_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.value     = m_tdata[31:0];
      got.segment   = m_tdata[35:32];
      got.status    = m_tdata[37:36];
      got.saturated = m_tdata[38];
      got.channel   = m_tuser;
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: value %0d ch %0d seg %0d status %0d sat %0d",
                   $signed(got.value), got.channel, got.segment, got.status,
                   got.saturated);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value || got.channel !== want.channel ||
            got.segment !== want.segment || got.status !== want.status ||
            got.saturated !== want.saturated) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on result %0d: expected value %0d ch %0d seg %0d status %0d sat %0d",
                     results_seen, $signed(want.value), want.channel, want.segment,
                     want.status, want.saturated);
            $display("  got value %0d ch %0d seg %0d status %0d sat %0d",
                     $signed(got.value), got.channel, got.segment, got.status,
                     got.saturated);
          end
        end
      end
    end
  end

  task automatic push_write(input logic ch, input logic [IDX_W-1:0] idx,
                            input logic signed [RAW_W-1:0] raw,
                            input logic signed [TGT_W-1:0] tgt);
    pcal_item_t it;
    it.op          = OP_WRITE;
    it.channel     = ch;
    it.point_index = idx;
    it.raw         = raw;
    it.target      = tgt;
    pending_items.push_back(it);
    plan_raw[ch][idx] = raw;
  endtask

  // Target and index ride along unused on a convert
  task automatic push_convert(input logic ch, input logic signed [RAW_W-1:0] raw);
    pcal_item_t it;
    it.op          = OP_CONVERT;
    it.channel     = ch;
    it.point_index = IDX_W'($urandom_range(N_POINTS - 1));
    it.raw         = raw;
    it.target      = $urandom;
    pending_items.push_back(it);
  endtask

  // Wait for the stream to empty, then for the sequencer to go quiet
  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_counts(input logic [CNT_W-1:0] w, input logic [CNT_W-1:0] d);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WEIGHT_POINTS;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_DISTANCE_POINTS;
    cfg_data  <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pts_used[CH_WEIGHT]   = w;
    pts_used[CH_DISTANCE] = d;
  endtask

  // Rewrite a whole table with ascending raws; narrow spans give equal raws
  task automatic load_table(input logic ch);
    int vals[$];
    int base, span, k, v, tmode, step_acc;
    logic signed [TGT_W-1:0] tg;
    k     = $urandom_range(3);
    base  = int'($urandom_range(16777215)) - 8388608;
    span  = (k == 1) ? (1 << $urandom_range(2, 22)) : 40;
    tmode = $urandom_range(2);
    for (int i = 0; i < N_POINTS; i++) begin
      if (k == 0 || k == 3) v = int'($urandom_range(16777215)) - 8388608;
      else v = base + int'($urandom_range(span));
      if (v > 8388607) v = 8388607;
      vals.push_back(v);
    end
    vals.sort();
    step_acc = int'($urandom_range(2097152)) - 1048576;
    for (int i = 0; i < N_POINTS; i++) begin
      if (tmode == 0) begin
        tg = $urandom;
      end else if (tmode == 1) begin
        tg = int'($urandom_range(2097152)) - 1048576;
      end else begin
        step_acc += int'($urandom_range(65536));
        tg = step_acc;
      end
      push_write(ch, i[IDX_W-1:0], RAW_W'(vals[i]), tg);
    end
  endtask

  // Stimulus
  initial begin : stim
    int          n, j, lo, hi, pick, phase_items, nw, nd;
    logic        ch;
    logic signed [RAW_W-1:0] x;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Empty tables: weight gives zero, distance passes raw through
    push_convert(CH_WEIGHT, 24'sd123);
    push_convert(CH_DISTANCE, 24'sh7FFFFF);
    push_convert(CH_DISTANCE, 24'sh800000);
    push_convert(CH_DISTANCE, 24'sd100);
    push_convert(CH_DISTANCE, 24'sd32767);
    push_convert(CH_DISTANCE, 24'sd32768);
    push_convert(CH_DISTANCE, -24'sd32768);
    push_convert(CH_DISTANCE, -24'sd32769);

    // Small tables with extreme targets and a flat last segment
    push_write(CH_WEIGHT, 4'd0, 24'sh800000, 32'sh8000_0000);
    push_write(CH_WEIGHT, 4'd1, -24'sd1000, 32'sd0);
    push_write(CH_WEIGHT, 4'd2, 24'sd1000, 32'sh7FFF_FFFF);
    push_write(CH_WEIGHT, 4'd3, 24'sd1000, 32'sd5);
    push_write(CH_DISTANCE, 4'd0, 24'sd0, 32'sd0);
    push_write(CH_DISTANCE, 4'd1, 24'sd1, 32'sh7FFF_FFFF);

    // Single point gives its target
    set_counts(5'd1, 5'd0);
    push_convert(CH_WEIGHT, 24'sd77);

    // Interpolation, flat segment, and extrapolation that saturates both ways
    set_counts(5'd4, 5'd2);
    push_convert(CH_WEIGHT, 24'sh800000);
    push_convert(CH_WEIGHT, 24'sd0);
    push_convert(CH_WEIGHT, 24'sd500);
    push_convert(CH_WEIGHT, 24'sd1000);
    push_convert(CH_WEIGHT, 24'sh7FFFFF);
    push_convert(CH_DISTANCE, 24'sh7FFFFF);
    push_convert(CH_DISTANCE, 24'sh800000);
    push_convert(CH_DISTANCE, 24'sd0);

    // Fill every entry of both tables before any larger count is used
    load_table(CH_WEIGHT);
    load_table(CH_DISTANCE);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin nw = 16; nd = 16; end
        1: begin nw = 2;  nd = 2;  end
        2: begin nw = 0;  nd = 1;  end
        3: begin nw = 31; nd = 3;  end
        4: begin nw = 1;  nd = 0;  end
        5: begin nw = 16; nd = 31; end
        default: begin
          nw = $urandom_range(16);
          nd = $urandom_range(16);
        end
      endcase
      set_counts(nw[CNT_W-1:0], nd[CNT_W-1:0]);

      phase_items = 0;
      if ($urandom_range(1)) begin
        load_table(CH_WEIGHT);
        phase_items += N_POINTS;
      end
      if ($urandom_range(1)) begin
        load_table(CH_DISTANCE);
        phase_items += N_POINTS;
      end

      while (phase_items < 110) begin
        ch = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 15) begin
          // stray point write, may break the raw ordering
          j = $urandom_range(N_POINTS - 1);
          if ($urandom_range(1)) x = RAW_W'($urandom);
          else x = RAW_W'(plan_raw[ch][j] + int'($urandom_range(64)) - 32);
          push_write(ch, j[IDX_W-1:0], x, $urandom);
        end else begin
          n = pts_used[ch];
          if (n > N_POINTS) n = N_POINTS;
          if (n == 0) n = 1;
          lo = plan_raw[ch][0];
          hi = plan_raw[ch][0];
          for (int q = 1; q < n; q++) begin
            if (plan_raw[ch][q] < lo) lo = plan_raw[ch][q];
            if (plan_raw[ch][q] > hi) hi = plan_raw[ch][q];
          end
          j = $urandom_range(n - 1);
          pick = $urandom_range(99);
          if (pick < 10)      x = RAW_W'($urandom);
          else if (pick < 15) x = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
          else if (pick < 40) x = RAW_W'(plan_raw[ch][j]);
          else if (pick < 70) x = RAW_W'(lo + int'($urandom_range(hi - lo)));
          else                x = RAW_W'(plan_raw[ch][j] + int'($urandom_range(64)) - 32);
          push_convert(ch, x);
        end
        phase_items++;
      end
    end

    drain();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pcal_pkg.sv
rtl/pcal_ram.sv
rtl/pcal_div.sv
rtl/pcal_seq.sv
rtl/piecewise_linear_calibration_top.sv
test/tb_top.sv
